### rtl/core/aabb_clip_depth_range_macros.svh
// Assertion macros shared by the depth-range fit RTL.
// Needs a clock named clock and an active-high reset named reset in the using module.
`ifndef AABB_CLIP_DEPTH_RANGE_MACROS_SVH
`define AABB_CLIP_DEPTH_RANGE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ACDR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition must never be seen outside reset.
`define ACDR_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ACDR_ASSERT(label, prop, msg)
`define ACDR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/core/acdr_pkg.sv
// Package for the depth-range fit block: sequencer states, register indexes,
// the fixed box triangle table and the vertex ordering helper. No dependencies.
package acdr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_TRIS  = 12;
   localparam int TRI_W     = 4;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_Y = 3'd3;

   // Fraction 1.0 in unsigned Q1.16.
   localparam logic [FRAC_BITS:0] T_ONE = 17'h10000;

   localparam logic [1:0] LAST_VTX  = 2'd2;
   localparam logic [1:0] LAST_PLANE = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_INIT,
      ST_PLANE,
      ST_TRI,
      ST_CLASS,
      ST_CP_SUB,
      ST_CP_MAG,
      ST_CP_CHK,
      ST_CP_DIV,
      ST_CP_DIFF,
      ST_CP_ABS,
      ST_CP_MULH,
      ST_CP_MULL,
      ST_CP_SUM,
      ST_CP_OUT,
      ST_WR_ONE,
      ST_WR_NEW,
      ST_WR_CUR,
      ST_SCAN,
      ST_ZCMP,
      ST_DONE
   } state_type;

   // Entry v holds the source vertex that lands in slot v.
   typedef logic [2:0][1:0] order_type;

   // Corner indexes of the twelve box triangles.
   localparam logic [2:0] BOX_TRIS [NUM_TRIS][3] = '{
      '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd3},
      '{3'd4, 3'd5, 3'd6}, '{3'd5, 3'd6, 3'd7},
      '{3'd0, 3'd2, 3'd4}, '{3'd2, 3'd4, 3'd6},
      '{3'd1, 3'd3, 3'd5}, '{3'd3, 3'd5, 3'd7},
      '{3'd0, 3'd1, 3'd4}, '{3'd1, 3'd4, 3'd5},
      '{3'd2, 3'd3, 3'd6}, '{3'd3, 3'd6, 3'd7}
   };

   // Stable partition: vertices inside the plane first, each group in its
   // original order.
   function automatic order_type stable_order(input logic [2:0] in_v);
      order_type o;
      o[0] = 2'd0;
      o[1] = 2'd1;
      o[2] = 2'd2;
      case (in_v)
         3'b010: begin
            o[0] = 2'd1; o[1] = 2'd0; o[2] = 2'd2;
         end
         3'b100: begin
            o[0] = 2'd2; o[1] = 2'd0; o[2] = 2'd1;
         end
         3'b101: begin
            o[0] = 2'd0; o[1] = 2'd2; o[2] = 2'd1;
         end
         3'b110: begin
            o[0] = 2'd1; o[1] = 2'd2; o[2] = 2'd0;
         end
         default: begin
            o[0] = 2'd0; o[1] = 2'd1; o[2] = 2'd2;
         end
      endcase
      return o;
   endfunction

endpackage

### rtl/core/aabb_clip_depth_range.sv
// Depth-range fit of a box against a rectangular clip window (top level).
// Depends on acdr_pkg and aabb_clip_depth_range_macros.svh.
//
// Usage: the eight light-space box corners arrive one word each on the
// req_ channel; a word is taken at a clock edge where start is high and busy
// is low. A corner without req_last_corner is stored as it is taken and busy
// stays low, so such words can follow back to back. The word marked
// req_last_corner is stored too and then starts the fit: the twelve box
// triangles are clipped one after another against the four window edges in
// a small work list, and the least and greatest z of the surviving vertices
// are collected. busy stays high until the fit is done, and the result word
// then shows for exactly one cycle with rsp_strobe high. The receiver cannot
// stall the result channel, so no backpressure is needed on it.
// Each clip point goes through the shared unit: a 16-step restoring divider
// for the edge fraction when it lies below 1.0, then two multiplier passes
// (high and low half of the magnitude) per component.
// csr_ writes set the window edges; they are taken only while idle.
// Reset returns the sequencer to idle, zeroes the edges and the list count;
// corner and work list storage hold garbage until written.
`include "aabb_clip_depth_range_macros.svh"

module aabb_clip_depth_range
   import acdr_pkg::*;
#(
   parameter int COORD_WIDTH     = 32,
   parameter int WORK_LIST_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Corner input.
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_corner_index,
   input  logic signed [COORD_WIDTH-1:0] req_corner_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner_z,
   input  logic                          req_last_corner,
   // Depth range result.
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_near_z,
   output logic signed [COORD_WIDTH-1:0] rsp_far_z,
   output logic                          rsp_any_kept,
   // Window edge registers.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata
);

   localparam int CW      = COORD_WIDTH;
   localparam int MAG_W   = CW + 1;
   localparam int HI_W    = MAG_W - FRAC_BITS;
   localparam int MUL_A_W = (HI_W > FRAC_BITS) ? HI_W : FRAC_BITS;
   localparam int MUL_P_W = MUL_A_W + FRAC_BITS + 1;
   localparam int S_W     = CW + 2;
   localparam int ROW_W   = 9 * CW;
   localparam int IDX_W   = $clog2(WORK_LIST_DEPTH);
   localparam int CNT_W   = $clog2(WORK_LIST_DEPTH + 1);

   localparam logic [CNT_W-1:0]     LIST_FULL = CNT_W'(WORK_LIST_DEPTH);
   localparam logic signed [CW-1:0] Z_MAX     = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] Z_MIN     = {1'b1, {(CW-1){1'b0}}};

   // Sequencer.
   state_type state_ff, state_in;

   // Corner store and window edges.
   logic signed [CW-1:0] corner_x_ff [8];
   logic signed [CW-1:0] corner_y_ff [8];
   logic signed [CW-1:0] corner_z_ff [8];
   logic signed [CW-1:0] clip_ff [4];

   // Work list: one row per triangle, three vertices of x, y, z.
   logic [ROW_W-1:0]             wl_mem [WORK_LIST_DEPTH];
   logic [ROW_W-1:0]             rd_row_ff;
   logic [WORK_LIST_DEPTH-1:0]   culled_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             lim_ff;
   logic [CNT_W-1:0]             idx_ff;

   // Loop counters.
   logic [1:0]       plane_ff;
   logic [TRI_W-1:0] tri_ff;
   logic [1:0]       vtx_ff;
   logic [1:0]       comp_ff;
   logic [3:0]       step_ff;
   logic             cp_ff;
   logic [1:0]       n_ff;

   // Current triangle and the two clip points.
   logic signed [CW-1:0] cur_ff [3][3];
   logic signed [CW-1:0] res_ff [2][3];

   // Shared clip unit.
   logic signed [CW:0]   h_ff;
   logic signed [CW:0]   dc_ff;
   logic signed [CW:0]   d_ff;
   logic [MAG_W-1:0]     a_ff;
   logic [MAG_W-1:0]     b_ff;
   logic [MAG_W-1:0]     r_ff;
   logic [MAG_W-1:0]     m_ff;
   logic                 ok_ff;
   logic                 neg_ff;
   logic [FRAC_BITS:0]   t_ff;
   logic [S_W-1:0]       hi_ff;
   logic [S_W-1:0]       lo_ff;
   logic [S_W-1:0]       s_ff;

   // Result.
   logic signed [CW-1:0] near_ff;
   logic signed [CW-1:0] far_ff;
   logic                 kept_ff;
   logic                 strobe_ff;

   // Combinational helpers.
   logic                 accept;
   logic                 axis;
   logic                 upper;
   logic signed [CW-1:0] edge_val;
   logic signed [CW-1:0] rd_vtx [3][3];
   logic [2:0]           in_v;
   order_type            order;
   logic [1:0]           n_in;
   logic [IDX_W-1:0]     idx_short;
   logic [IDX_W-1:0]     cnt_short;
   logic                 idx_culled;
   logic                 room;
   logic [1:0]           psel;
   logic [1:0]           qsel;
   logic signed [CW-1:0] p_axis;
   logic signed [CW-1:0] q_axis;
   logic signed [CW-1:0] p_comp;
   logic signed [CW-1:0] q_comp;
   logic [MAG_W-1:0]     div_r2;
   logic                 div_ge;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_P_W-1:0]   mul_p;
   logic [S_W-1:0]       out_wide;
   logic signed [CW-1:0] z_cur;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic signed [CW-1:0] wr_vtx [3][3];
   logic [ROW_W-1:0]     wr_row;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign csr_ready    = (state_ff == ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_near_z   = near_ff;
   assign rsp_far_z    = far_ff;
   assign rsp_any_kept = kept_ff;

   // Plane order is min x, max x, min y, max y, same as the edge registers.
   assign axis     = plane_ff[1];
   assign upper    = plane_ff[0];
   assign edge_val = clip_ff[plane_ff];

   assign idx_short  = idx_ff[IDX_W-1:0];
   assign cnt_short  = cnt_ff[IDX_W-1:0];
   assign idx_culled = culled_ff[idx_short];
   assign room       = (cnt_ff < LIST_FULL);

   // Unpack the registered work list row and classify it against the plane.
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            rd_vtx[v][k] = rd_row_ff[(v*3+k)*CW +: CW];
         end
         in_v[v] = upper ? (rd_vtx[v][axis] < edge_val) : (rd_vtx[v][axis] > edge_val);
      end
      order = stable_order(in_v);
      n_in  = 2'(in_v[0]) + 2'(in_v[1]) + 2'(in_v[2]);
   end

   // Clip point end points. With one vertex inside, both segments start at
   // that vertex; with two inside, both start at the outside vertex.
   always_comb begin
      psel   = (n_ff == 2'd1) ? 2'd0 : 2'd2;
      if (n_ff == 2'd1) begin
         qsel = cp_ff ? 2'd2 : 2'd1;
      end else begin
         qsel = cp_ff ? 2'd1 : 2'd0;
      end
      p_axis = axis ? cur_ff[psel][1] : cur_ff[psel][0];
      q_axis = axis ? cur_ff[qsel][1] : cur_ff[qsel][0];
      p_comp = cur_ff[psel][comp_ff];
      q_comp = cur_ff[qsel][comp_ff];
   end

   // One restoring division step, one multiplier, one signed add.
   assign div_r2   = {r_ff[MAG_W-2:0], 1'b0};
   assign div_ge   = (div_r2 >= b_ff);
   assign mul_a    = (state_ff == ST_CP_MULH) ? MUL_A_W'(m_ff[MAG_W-1:FRAC_BITS])
                                              : MUL_A_W'(m_ff[FRAC_BITS-1:0]);
   assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(t_ff);
   assign out_wide = neg_ff ? ({{2{p_comp[CW-1]}}, p_comp} - s_ff)
                            : ({{2{p_comp[CW-1]}}, p_comp} + s_ff);
   assign z_cur    = rd_vtx[vtx_ff][2];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_corner) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (vtx_ff == LAST_VTX) state_in = ST_INIT;
         end
         ST_INIT:  state_in = ST_PLANE;
         ST_PLANE: state_in = ST_TRI;
         ST_TRI: begin
            if (idx_ff >= lim_ff) begin
               state_in = (plane_ff == LAST_PLANE) ? ST_SCAN : ST_PLANE;
            end else if (!idx_culled) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            state_in = (n_in == 2'd1 || n_in == 2'd2) ? ST_CP_SUB : ST_TRI;
         end
         ST_CP_SUB: state_in = ST_CP_MAG;
         ST_CP_MAG: state_in = ST_CP_CHK;
         ST_CP_CHK: begin
            state_in = (ok_ff && (a_ff < b_ff)) ? ST_CP_DIV : ST_CP_DIFF;
         end
         ST_CP_DIV: begin
            if (step_ff == 4'd15) state_in = ST_CP_DIFF;
         end
         ST_CP_DIFF: state_in = ST_CP_ABS;
         ST_CP_ABS:  state_in = ST_CP_MULH;
         ST_CP_MULH: state_in = ST_CP_MULL;
         ST_CP_MULL: state_in = ST_CP_SUM;
         ST_CP_SUM:  state_in = ST_CP_OUT;
         ST_CP_OUT: begin
            if (comp_ff != LAST_VTX) begin
               state_in = ST_CP_DIFF;
            end else if (!cp_ff) begin
               state_in = ST_CP_SUB;
            end else begin
               state_in = (n_ff == 2'd1) ? ST_WR_ONE : ST_WR_NEW;
            end
         end
         ST_WR_ONE: state_in = ST_TRI;
         ST_WR_NEW: state_in = ST_WR_CUR;
         ST_WR_CUR: state_in = ST_TRI;
         ST_SCAN: begin
            if (idx_ff >= cnt_ff) begin
               state_in = (tri_ff == TRI_W'(NUM_TRIS - 1)) ? ST_DONE : ST_LOAD;
            end else if (!idx_culled) begin
               state_in = ST_ZCMP;
            end
         end
         ST_ZCMP: begin
            if (vtx_ff == LAST_VTX) state_in = ST_SCAN;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Work list write port. A one-inside clip reshapes the triangle in place;
   // a two-inside clip appends one piece when the list has room and rewrites the current slot.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_short;
      for (int k = 0; k < 3; k++) begin
         wr_vtx[0][k] = cur_ff[0][k];
         wr_vtx[1][k] = cur_ff[1][k];
         wr_vtx[2][k] = cur_ff[2][k];
      end
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         ST_WR_ONE: begin
            wr_en = 1'b1;
            for (int k = 0; k < 3; k++) begin
               wr_vtx[1][k] = res_ff[1][k];
               wr_vtx[2][k] = res_ff[0][k];
            end
         end
         ST_WR_NEW: begin
            wr_en   = room;
            wr_addr = cnt_short;
            for (int k = 0; k < 3; k++) begin
               wr_vtx[2][k] = res_ff[0][k];
            end
         end
         ST_WR_CUR: begin
            wr_en = 1'b1;
            for (int k = 0; k < 3; k++) begin
               wr_vtx[0][k] = cur_ff[1][k];
               wr_vtx[1][k] = res_ff[0][k];
               wr_vtx[2][k] = res_ff[1][k];
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            wr_row[(v*3+k)*CW +: CW] = wr_vtx[v][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) wl_mem[wr_addr] <= wr_row;
      rd_row_ff <= wl_mem[idx_short];
   end

   // Corner store and edge registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         corner_x_ff[req_corner_index] <= req_corner_x;
         corner_y_ff[req_corner_index] <= req_corner_y;
         corner_z_ff[req_corner_index] <= req_corner_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) clip_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLIP_MIN_X: clip_ff[0] <= csr_wdata;
            CSR_CLIP_MAX_X: clip_ff[1] <= csr_wdata;
            CSR_CLIP_MIN_Y: clip_ff[2] <= csr_wdata;
            CSR_CLIP_MAX_Y: clip_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // List count, depth range and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         near_ff   <= Z_MAX;
         far_ff    <= Z_MIN;
         kept_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == ST_DONE);
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_last_corner) begin
                  near_ff <= Z_MAX;
                  far_ff  <= Z_MIN;
                  kept_ff <= 1'b0;
               end
            end
            ST_INIT: cnt_ff <= CNT_W'(1);
            ST_WR_NEW: begin
               if (room) cnt_ff <= cnt_ff + CNT_W'(1);
            end
            ST_ZCMP: begin
               kept_ff <= 1'b1;
               if (z_cur < near_ff) near_ff <= z_cur;
               if (z_cur > far_ff) far_ff <= z_cur;
            end
            default: ;
         endcase
      end
   end

   // Loop counters, triangle registers and the shared clip unit.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            vtx_ff <= '0;
            tri_ff <= '0;
         end
         ST_LOAD: begin
            cur_ff[vtx_ff][0] <= corner_x_ff[BOX_TRIS[tri_ff][vtx_ff]];
            cur_ff[vtx_ff][1] <= corner_y_ff[BOX_TRIS[tri_ff][vtx_ff]];
            cur_ff[vtx_ff][2] <= corner_z_ff[BOX_TRIS[tri_ff][vtx_ff]];
            vtx_ff <= (vtx_ff == LAST_VTX) ? 2'd0 : vtx_ff + 2'd1;
         end
         ST_INIT: begin
            culled_ff[0] <= 1'b0;
            plane_ff     <= '0;
         end
         ST_PLANE: begin
            lim_ff <= cnt_ff;
            idx_ff <= '0;
         end
         ST_TRI: begin
            if (idx_ff >= lim_ff) begin
               if (plane_ff == LAST_PLANE) begin
                  idx_ff <= '0;
               end else begin
                  plane_ff <= plane_ff + 2'd1;
               end
            end else if (idx_culled) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         ST_CLASS: begin
            for (int v = 0; v < 3; v++) begin
               for (int k = 0; k < 3; k++) begin
                  cur_ff[v][k] <= rd_vtx[order[v]][k];
               end
            end
            n_ff  <= n_in;
            cp_ff <= 1'b0;
            if (n_in == 2'd0) culled_ff[idx_short] <= 1'b1;
            if (n_in == 2'd0 || n_in == 2'd3) idx_ff <= idx_ff + CNT_W'(1);
         end
         ST_CP_SUB: begin
            h_ff    <= {edge_val[CW-1], edge_val} - {p_axis[CW-1], p_axis};
            dc_ff   <= {q_axis[CW-1], q_axis} - {p_axis[CW-1], p_axis};
            comp_ff <= '0;
         end
         ST_CP_MAG: begin
            a_ff  <= h_ff[CW] ? MAG_W'(~h_ff) + MAG_W'(1) : MAG_W'(h_ff);
            b_ff  <= dc_ff[CW] ? MAG_W'(~dc_ff) + MAG_W'(1) : MAG_W'(dc_ff);
            // The fraction is only taken when the edge lies toward Q.
            ok_ff <= (dc_ff != '0) && ((h_ff[CW] == dc_ff[CW]) || (h_ff == '0));
         end
         ST_CP_CHK: begin
            r_ff    <= a_ff;
            step_ff <= '0;
            t_ff    <= (ok_ff && (a_ff >= b_ff)) ? T_ONE : '0;
         end
         ST_CP_DIV: begin
            r_ff    <= div_ge ? div_r2 - b_ff : div_r2;
            t_ff    <= {t_ff[FRAC_BITS-1:0], div_ge};
            step_ff <= step_ff + 4'd1;
         end
         ST_CP_DIFF: begin
            d_ff <= {q_comp[CW-1], q_comp} - {p_comp[CW-1], p_comp};
         end
         ST_CP_ABS: begin
            m_ff   <= d_ff[CW] ? MAG_W'(~d_ff) + MAG_W'(1) : MAG_W'(d_ff);
            neg_ff <= d_ff[CW];
         end
         ST_CP_MULH: hi_ff <= S_W'(mul_p);
         ST_CP_MULL: lo_ff <= S_W'(mul_p >> FRAC_BITS);
         ST_CP_SUM:  s_ff  <= hi_ff + lo_ff;
         ST_CP_OUT: begin
            // The point lies between P and Q, so it fits the coordinate width.
            res_ff[cp_ff][comp_ff] <= out_wide[CW-1:0];
            if (comp_ff == LAST_VTX) begin
               comp_ff <= '0;
               cp_ff   <= 1'b1;
            end else begin
               comp_ff <= comp_ff + 2'd1;
            end
         end
         ST_WR_ONE: idx_ff <= idx_ff + CNT_W'(1);
         ST_WR_NEW: begin
            if (room) culled_ff[cnt_short] <= 1'b0;
         end
         ST_WR_CUR: idx_ff <= idx_ff + CNT_W'(1);
         ST_SCAN: begin
            vtx_ff <= '0;
            if (idx_ff >= cnt_ff) begin
               tri_ff <= tri_ff + TRI_W'(1);
            end else if (idx_culled) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         ST_ZCMP: begin
            if (vtx_ff == LAST_VTX) begin
               vtx_ff <= '0;
               idx_ff <= idx_ff + CNT_W'(1);
            end else begin
               vtx_ff <= vtx_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // A result word only follows the final sequencer step.
   `ACDR_ASSERT(a_strobe_after_done, rsp_strobe |-> $past(state_ff == ST_DONE), "result without fit")
   // The work list never grows past its depth.
   `ACDR_ASSERT_NEVER(a_list_bound, cnt_ff > LIST_FULL, "work list overflow")
   // A kept range is ordered.
   `ACDR_ASSERT(a_range_order, (rsp_strobe && rsp_any_kept) |-> (rsp_near_z <= rsp_far_z), "near above far")
   // An empty result carries the reset extremes.
   `ACDR_ASSERT(a_empty_range, (rsp_strobe && !rsp_any_kept) |-> (rsp_near_z == Z_MAX && rsp_far_z == Z_MIN), "bad empty range")

endmodule
